### src/sdwr_pkg.sv
// shared types and constants for the serial draw without replacement block
package sdwr_pkg;

  // configuration register indexes
  localparam logic CFG_RANGE_START = 1'b0;
  localparam logic CFG_RANGE_SIZE  = 1'b1;

  // field widths fixed by the interface
  localparam int WORD_W  = 16;
  localparam int SIZE_W  = 7;
  localparam int VALUE_W = 17;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MULT,
    ST_SCAN
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;   // capture the random word
    logic setup;    // scale the word to an unused-index rank
    logic step;     // advance the map scan by one bit
    logic finish;   // load the result and mark the index used
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic found;    // scan sits on the selected unused index
    logic out_free; // output register can take a new item
  } status_t;

endpackage

### src/sdwr_ctrl.sv
// controller state machine for the draw sequence
module sdwr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sdwr_pkg::status_t status,
  output sdwr_pkg::cmd_t    cmd
);
  import sdwr_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd.setup  = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.found) begin
          // hold on the found index until the output register frees up
          if (status.out_free) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/sdwr_datapath.sv
// datapath: config registers, used map, rank scaling, map scan and output register
module sdwr_datapath #(
  parameter int MAX_SIZE = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_index,
  input  logic [sdwr_pkg::WORD_W-1:0]     cfg_data,
  input  logic [sdwr_pkg::WORD_W-1:0]     in_word,
  input  sdwr_pkg::cmd_t                  cmd,
  output sdwr_pkg::status_t               status,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [sdwr_pkg::VALUE_W-1:0] out_value,
  output logic                            out_done
);
  import sdwr_pkg::*;

  localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam logic [SIZE_W-1:0] SIZE_CAP =
    SIZE_W'((MAX_SIZE > (2 ** SIZE_W) - 1) ? (2 ** SIZE_W) - 1 : MAX_SIZE);

  // effective series length for a size register value
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_CAP) begin
      r = SIZE_CAP;
    end else begin
      r = s;
    end
    return r;
  endfunction

  logic signed [WORD_W-1:0] range_start;
  logic [SIZE_W-1:0]        range_size;
  logic [MAX_SIZE-1:0]      used_map;
  logic [SIZE_W-1:0]        remaining;
  logic [WORD_W-1:0]        word;
  logic [SIZE_W-1:0]        rank;
  logic [SIZE_W-1:0]        seen;
  logic [IDX_W-1:0]         idx;

  logic [SIZE_W-1:0]        size_now;
  logic                     rem_bad;
  logic [SIZE_W-1:0]        rem_use;
  logic [WORD_W+SIZE_W-1:0] product;
  logic                     cur_free;
  logic [SIZE_W-1:0]        rem_dec;
  logic                     last_draw;

  assign size_now = eff_size(range_size);
  assign rem_bad  = (remaining == '0) || (remaining > size_now);
  assign rem_use  = rem_bad ? size_now : remaining;
  assign product  = word * rem_use;
  assign cur_free = ~used_map[idx];
  assign rem_dec  = remaining - SIZE_W'(1);
  assign last_draw = (rem_dec == '0);

  assign status.found    = cur_free && (seen == rank);
  assign status.out_free = ~out_valid | out_ready;

  // config registers, map and remaining count
  always_ff @(posedge clk) begin
    if (rst) begin
      range_start <= '0;
      range_size  <= SIZE_W'(64);
      used_map    <= '0;
      remaining   <= eff_size(SIZE_W'(64));
    end else if (cfg_valid) begin
      // any register write restarts the series
      used_map <= '0;
      case (cfg_index)
        CFG_RANGE_START: begin
          range_start <= cfg_data;
          remaining   <= size_now;
        end
        CFG_RANGE_SIZE: begin
          range_size <= cfg_data[SIZE_W-1:0];
          remaining  <= eff_size(cfg_data[SIZE_W-1:0]);
        end
        default: begin
          remaining <= size_now;
        end
      endcase
    end else if (cmd.setup) begin
      if (rem_bad) begin
        used_map  <= '0;
        remaining <= size_now;
      end
    end else if (cmd.finish) begin
      if (last_draw) begin
        used_map  <= '0;
        remaining <= size_now;
      end else begin
        used_map[idx] <= 1'b1;
        remaining     <= rem_dec;
      end
    end
  end

  // random word capture, rank scaling and map scan
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      word <= in_word;
    end
    if (cmd.setup) begin
      rank <= product[WORD_W+SIZE_W-1:WORD_W];
      seen <= '0;
      idx  <= '0;
    end else if (cmd.step) begin
      if (cur_free) begin
        seen <= seen + SIZE_W'(1);
      end
      idx <= idx + IDX_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value <= {range_start[WORD_W-1], range_start} + VALUE_W'(idx);
      out_done  <= last_draw;
    end
  end

endmodule

### src/serial_draw_without_replacement.sv
// top level of the serial draw without replacement block
//
// Draws every value of range_start .. range_start+size-1 once per series in an
// order picked by the incoming random words, then starts a new series. One
// random word in gives one value out; one item is in work at a time. After
// acceptance the random word is scaled by the remaining count, then the used
// map is scanned one bit per cycle up to the chosen index (below the series
// size, so at most 63 by default), and the result register is loaded. The next
// item can be accepted in the cycle after the result is loaded, even while it
// still waits at the output. A result that waits at the output holds the next
// item's result back until it is taken. A write to either config register
// restarts the series; writes belong to times when no item is in work.
module serial_draw_without_replacement #(
  parameter int MAX_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // random word items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] random_word
  // drawn value items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [16:0] drawn_value, [23:17] zero
  output logic        m_tuser    // [0] series_done
);
  import sdwr_pkg::*;

  cmd_t                       cmd;
  status_t                    status;
  logic signed [VALUE_W-1:0]  value;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {7'b0, value};

  // sequence control
  sdwr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // map, scan and result
  sdwr_datapath #(
    .MAX_SIZE (MAX_SIZE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (value),
    .out_done  (m_tuser)
  );

endmodule
